/* rtl/tachometer_period_rpm_top_defines.svh */
// Assertion macros for the tachometer block.
// Included by the top level; no other dependencies.
`ifndef TACHOMETER_PERIOD_RPM_TOP_DEFINES_SVH
`define TACHOMETER_PERIOD_RPM_TOP_DEFINES_SVH

`ifndef SYNTH
// same-cycle implication
`define TPR_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("tpr assertion failed");
// next-cycle implication
`define TPR_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("tpr assertion failed");
`else
`define TPR_ASSERT_IMP(label, ante, cons)
`define TPR_ASSERT_NXT(label, ante, cons)
`endif

`endif

/* rtl/tpr_pkg.sv */
// Shared constants, types and register codes for the tachometer block.
// No dependencies.
package tpr_pkg;

  localparam int PERIOD_BITS   = 16;
  localparam int PRESCALE_BITS = 10;
  localparam int DIV_BITS      = 11;
  localparam int FREQ_BITS     = 24;
  localparam int PPR_BITS      = 8;
  localparam int RPM_BITS      = 30;
  localparam int DEN_BITS      = PERIOD_BITS + PPR_BITS;
  localparam int CNT_BITS      = $clog2(RPM_BITS);
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = FREQ_BITS;

  localparam logic [PERIOD_BITS-1:0] PERIOD_TOP     = '1;
  localparam logic [DIV_BITS-1:0]    PRESCALE_LIMIT = DIV_BITS'(1 << PRESCALE_BITS);
  localparam logic [RPM_BITS-1:0]    RPM_MAX        = RPM_BITS'(1000000000);
  localparam logic [5:0]             SECONDS_PER_MINUTE = 6'd60;

  localparam logic [DIV_BITS-1:0]  PRESCALE_DIV_RST   = DIV_BITS'(1024);
  localparam logic [FREQ_BITS-1:0] TIMER_FREQ_RST     = FREQ_BITS'(15625);
  localparam logic [PPR_BITS-1:0]  PULSES_PER_REV_RST = PPR_BITS'(7);

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_PRESCALE_DIV,
    CFG_TIMER_FREQ,
    CFG_PULSES_PER_REV
  } tpr_cfg_idx_e;

  typedef enum logic [1:0] {
    B_IDLE,
    B_DIV,
    B_DONE
  } tpr_bstate_e;

  typedef struct packed {
    logic [DIV_BITS-1:0]  prescale_div;
    logic [FREQ_BITS-1:0] timer_freq;
    logic [PPR_BITS-1:0]  pulses_per_rev;
  } tpr_cfg_t;

  // one captured period waiting for conversion
  typedef struct packed {
    logic [PERIOD_BITS-1:0] period;
    logic                   saturated;
  } tpr_entry_t;

  typedef struct packed {
    logic empty;
    logic full;
  } tpr_qstat_t;

endpackage

/* rtl/tpr_front.sv */
// Front end: prescaler, period counter and sensor edge detection.
// Pushes one captured period per rising edge of an accepted sample. Depends on tpr_pkg.
module tpr_front import tpr_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  tpr_cfg_t   cfg_i,
  input  logic       accept_i,
  input  logic       sensor_level_i,
  output logic       push_o,
  output tpr_entry_t entry_o
);

  logic [PRESCALE_BITS-1:0] pre_q, pre_d;
  logic [PERIOD_BITS-1:0]   cnt_q, cnt_d;
  logic                     sat_q, sat_d;
  logic                     lvl_q;
  logic [DIV_BITS-1:0]      ratio_m1;
  logic                     tick, rising;
  logic [PERIOD_BITS-1:0]   base;
  logic                     base_sat;

  always_comb begin
    if (cfg_i.prescale_div == '0) begin
      ratio_m1 = '0;
    end else if (cfg_i.prescale_div > PRESCALE_LIMIT) begin
      ratio_m1 = PRESCALE_LIMIT - DIV_BITS'(1);
    end else begin
      ratio_m1 = cfg_i.prescale_div - DIV_BITS'(1);
    end
  end

  assign tick   = DIV_BITS'(pre_q) >= ratio_m1;
  assign rising = sensor_level_i && !lvl_q;
  assign pre_d  = tick ? '0 : pre_q + PRESCALE_BITS'(1);

  // a tick in the capture cycle counts into the new period
  always_comb begin
    base     = rising ? '0 : cnt_q;
    base_sat = rising ? 1'b0 : sat_q;
    cnt_d    = base + PERIOD_BITS'(tick && (base != PERIOD_TOP));
    sat_d    = base_sat || (cnt_d == PERIOD_TOP);
  end

  assign push_o            = accept_i && rising;
  assign entry_o.period    = cnt_q;
  assign entry_o.saturated = sat_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pre_q <= '0;
      cnt_q <= '0;
      sat_q <= 1'b0;
      lvl_q <= 1'b0;
    end else if (accept_i) begin
      pre_q <= pre_d;
      cnt_q <= cnt_d;
      sat_q <= sat_d;
      lvl_q <= sensor_level_i;
    end
  end

endmodule

/* rtl/tpr_fifo.sv */
// Two-entry queue of captured periods between front and back end.
// Depends on tpr_pkg.
module tpr_fifo import tpr_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  tpr_entry_t entry_i,
  input  logic       pop_i,
  output tpr_entry_t head_o,
  output tpr_qstat_t stat_o
);

  tpr_entry_t mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] fill_q;

  assign head_o       = mem_q[rd_q];
  assign stat_o.empty = (fill_q == 2'd0);
  assign stat_o.full  = (fill_q == 2'd2);

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q   <= 1'b0;
      rd_q   <= 1'b0;
      fill_q <= 2'd0;
    end else begin
      if (push_i) begin
        wr_q <= ~wr_q;
      end
      if (pop_i) begin
        rd_q <= ~rd_q;
      end
      fill_q <= fill_q + 2'(push_i) - 2'(pop_i);
    end
  end

endmodule

/* rtl/tpr_back.sv */
// Back end: rpm conversion with a radix-2 restoring divider and output register.
// Depends on tpr_pkg.
module tpr_back import tpr_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  tpr_cfg_t               cfg_i,
  input  tpr_qstat_t             qstat_i,
  input  tpr_entry_t             head_i,
  output logic                   pop_o,
  input  logic                   out_stall_i,
  output logic                   out_valid_o,
  output logic [PERIOD_BITS-1:0] period_ticks_o,
  output logic [RPM_BITS-1:0]    rpm_o,
  output logic                   period_saturated_o,
  output logic                   period_zero_o
);

  tpr_bstate_e state_q, state_d;

  logic [DEN_BITS:0]      rem_q;
  logic [RPM_BITS-1:0]    quo_q;
  logic [DEN_BITS-1:0]    den_q;
  logic [CNT_BITS-1:0]    it_q;
  logic [PERIOD_BITS-1:0] per_q;
  logic                   sat_q;

  logic                   out_valid_q;
  logic [PERIOD_BITS-1:0] out_per_q;
  logic [RPM_BITS-1:0]    out_rpm_q;
  logic                   out_sat_q;
  logic                   out_zero_q;

  logic                last_it, out_free, load_out;
  logic [DEN_BITS:0]   rem_sh, rem_n;
  logic                ge;
  logic [RPM_BITS-1:0] rpm_fin;

  assign last_it  = (it_q == CNT_BITS'(RPM_BITS - 1));
  assign out_free = !out_valid_q || !out_stall_i;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      B_IDLE:  if (!qstat_i.empty) state_d = B_DIV;
      B_DIV:   if (last_it) state_d = B_DONE;
      B_DONE:  if (out_free) state_d = B_IDLE;
      default: state_d = B_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    pop_o    = 1'b0;
    load_out = 1'b0;
    case (state_q)
      B_IDLE:  pop_o = !qstat_i.empty;
      B_DONE:  load_out = out_free;
      default: ;
    endcase
  end

  always_comb begin
    rem_sh = {rem_q[DEN_BITS-1:0], quo_q[RPM_BITS-1]};
    ge     = rem_sh >= {1'b0, den_q};
    rem_n  = ge ? rem_sh - {1'b0, den_q} : rem_sh;
  end

  // zero divisor covers both a zero period and zero pulses per revolution
  always_comb begin
    if (den_q == '0 || quo_q > RPM_MAX) begin
      rpm_fin = RPM_MAX;
    end else begin
      rpm_fin = quo_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      quo_q <= RPM_BITS'(cfg_i.timer_freq) * RPM_BITS'(SECONDS_PER_MINUTE);
      den_q <= DEN_BITS'(head_i.period) * DEN_BITS'(cfg_i.pulses_per_rev);
      rem_q <= '0;
      it_q  <= '0;
      per_q <= head_i.period;
      sat_q <= head_i.saturated;
    end else if (state_q == B_DIV) begin
      rem_q <= rem_n;
      quo_q <= {quo_q[RPM_BITS-2:0], ge};
      it_q  <= it_q + CNT_BITS'(1);
    end
    if (load_out) begin
      out_per_q  <= per_q;
      out_rpm_q  <= rpm_fin;
      out_sat_q  <= sat_q;
      out_zero_q <= (per_q == '0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o        = out_valid_q;
  assign period_ticks_o     = out_per_q;
  assign rpm_o              = out_rpm_q;
  assign period_saturated_o = out_sat_q;
  assign period_zero_o      = out_zero_q;

endmodule

/* rtl/tachometer_period_rpm_top.sv */
// Top level of the period-measuring tachometer: config registers, front end,
// period queue and rpm back end. Depends on tpr_pkg, tpr_front, tpr_fifo, tpr_back.
//
//   channel  direction  handshake                 payload
//   in       input      in_valid_i / in_stall_o   sensor_level_i
//   out      output     out_valid_o / out_stall_i period_ticks_o, rpm_o,
//                                                 period_saturated_o, period_zero_o
//   cfg      input      cfg_we_i                  cfg_idx_i, cfg_data_i
//
// One sensor sample is taken per cycle unless stalled; edges without a result cost nothing.
// For each rising edge the back end loads the entry, runs 30 divider iterations
// (one quotient bit each), hands over to the output register, then pops the next entry.
// in_stall_o rises only while the two-entry period queue is full.
// Reset clears all control state; no clearing pass is needed.
`include "tachometer_period_rpm_top_defines.svh"

module tachometer_period_rpm_top import tpr_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_BITS-1:0] cfg_data_i,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic                     sensor_level_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [PERIOD_BITS-1:0]   period_ticks_o,
  output logic [RPM_BITS-1:0]      rpm_o,
  output logic                     period_saturated_o,
  output logic                     period_zero_o
);

  tpr_cfg_t   cfg_q;
  tpr_entry_t push_entry, head;
  tpr_qstat_t qstat;
  logic       accept, push, pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.prescale_div   <= PRESCALE_DIV_RST;
      cfg_q.timer_freq     <= TIMER_FREQ_RST;
      cfg_q.pulses_per_rev <= PULSES_PER_REV_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_PRESCALE_DIV:   cfg_q.prescale_div   <= cfg_data_i[DIV_BITS-1:0];
        CFG_TIMER_FREQ:     cfg_q.timer_freq     <= cfg_data_i[FREQ_BITS-1:0];
        CFG_PULSES_PER_REV: cfg_q.pulses_per_rev <= cfg_data_i[PPR_BITS-1:0];
        default: ;
      endcase
    end
  end

  assign in_stall_o = qstat.full;
  assign accept     = in_valid_i && !in_stall_o;

  tpr_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .accept_i       (accept),
    .sensor_level_i (sensor_level_i),
    .push_o         (push),
    .entry_o        (push_entry)
  );

  tpr_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .pop_i   (pop),
    .head_o  (head),
    .stat_o  (qstat)
  );

  tpr_back u_back (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_i              (cfg_q),
    .qstat_i            (qstat),
    .head_i             (head),
    .pop_o              (pop),
    .out_stall_i        (out_stall_i),
    .out_valid_o        (out_valid_o),
    .period_ticks_o     (period_ticks_o),
    .rpm_o              (rpm_o),
    .period_saturated_o (period_saturated_o),
    .period_zero_o      (period_zero_o)
  );

  // queue must never overflow or underflow
  `TPR_ASSERT_IMP(a_no_push_full, push, !qstat.full)
  `TPR_ASSERT_IMP(a_no_pop_empty, pop, !qstat.empty)
  // zero-period flag must track the captured period and force the maximum rpm
  `TPR_ASSERT_IMP(a_zero_flag, out_valid_o, period_zero_o == (period_ticks_o == '0))
  `TPR_ASSERT_IMP(a_zero_rpm, out_valid_o && period_zero_o, rpm_o == RPM_MAX)

endmodule
